// ----- sv/bb3_pkg.sv -----
`timescale 1ns / 1ps
package bb3_pkg;

  // Frame limits and derived widths
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;
  localparam int PIX_W        = 24;
  localparam int SUM_W        = 12;
  localparam int CNT_W        = 4;
  localparam int RECIP_W      = 18;
  localparam int NUM_W        = 13;
  localparam int PROD_W       = NUM_W + RECIP_W;
  localparam int QUOT_SHIFT   = 18;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic       action;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;
  } out_beat_t;

  // Item held while the line store read completes
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] col;
    pix_t             pix;
    logic             emit;
    logic             last;
    logic             left;
    logic             right;
    logic             top;
    logic             bottom;
    logic             fwd;
    pix_t             fwd_two;
    pix_t             fwd_one;
  } s1_t;

  // ceil(2^18 / (2*cnt)): exact rounded quotient for numerators below 2^13
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    unique case (cnt)
      CNT_W'(1): m = RECIP_W'(131072);
      CNT_W'(2): m = RECIP_W'(65536);
      CNT_W'(3): m = RECIP_W'(43691);
      CNT_W'(4): m = RECIP_W'(32768);
      CNT_W'(6): m = RECIP_W'(21846);
      CNT_W'(9): m = RECIP_W'(14564);
      default:   m = '0;
    endcase
    return m;
  endfunction

endpackage

// ----- sv/bb3_ram.sv -----
`timescale 1ns / 1ps
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; registered read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/box_blur_3x3_rgb_unit.sv -----
`timescale 1ns / 1ps
// 3x3 box blur over RGB frames in raster order.
// Input channel (in_valid/in_ready/in_data): a pixel beat (action 0) or a
// flush beat (action 1). Output channel (out_valid/out_ready/out_data): the
// rounded mean of the in-bounds 3x3 neighbourhood, frame_last on the last
// pixel of a frame. Results lag the pixel stream by width + 1 positions;
// once the whole frame is in, every further beat releases one pending result.
// Configuration: cfg_write with cfg_index selects image_width (0) or
// image_height (1); a write abandons the frame in progress. Write only idle.
// A released result passes the read stage, sum stage and output register.
// Throughput: one beat per clock while the receiver takes results, set by the
// read-modify-write of the two line stores (one read and one write per
// store each cycle, with forwarding when consecutive beats hit one column).
// Reset: sizes return to 640 x 480, the window and positions clear, the
// pipeline empties. Line store contents are not cleared.
// A stalled receiver holds the output register; the two internal stages
// fill behind it and in_ready drops until out_ready frees them.
module box_blur_3x3_rgb_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bb3_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bb3_pkg::out_beat_t             out_data,
  input  logic                           cfg_write,
  input  logic [bb3_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int COL_W = bb3_pkg::COL_W;
  localparam int ROW_W = bb3_pkg::ROW_W;
  localparam int SUM_W = bb3_pkg::SUM_W;
  localparam int CNT_W = bb3_pkg::CNT_W;

  // Configuration registers
  logic [bb3_pkg::WIDTH_REG_W-1:0]  image_width;
  logic [bb3_pkg::HEIGHT_REG_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bb3_pkg::WIDTH_RESET;
      image_height <= bb3_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (bb3_pkg::cfg_reg_t'(cfg_index))
        bb3_pkg::REG_WIDTH:  image_width  <= cfg_data[bb3_pkg::WIDTH_REG_W-1:0];
        bb3_pkg::REG_HEIGHT: image_height <= cfg_data[bb3_pkg::HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes to 1..max
  logic [COL_W:0]   w_eff;
  logic [ROW_W:0]   h_eff;
  logic [COL_W-1:0] w_m1;
  logic [ROW_W-1:0] h_m1;

  always_comb begin
    if (image_width == '0) begin
      w_eff = (COL_W+1)'(1);
    end else if (image_width > (COL_W+1)'(bb3_pkg::MAX_WIDTH)) begin
      w_eff = (COL_W+1)'(bb3_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = (ROW_W+1)'(1);
    end else if (image_height > (ROW_W+1)'(bb3_pkg::MAX_HEIGHT)) begin
      h_eff = (ROW_W+1)'(bb3_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
    w_m1 = COL_W'(w_eff - (COL_W+1)'(1));
    h_m1 = ROW_W'(h_eff - (ROW_W+1)'(1));
  end

  // Handshake chain: output register, sum stage, read stage
  bb3_pkg::s1_t s1;
  logic         s2_valid;
  logic         out_free;
  logic         s2_adv;
  logic         s2_free;
  logic         s1_move;
  logic         accept;

  assign out_free = !out_valid || out_ready;
  assign s2_adv   = s2_valid && out_free;
  assign s2_free  = !s2_valid || s2_adv;
  assign s1_move  = s1.valid && s2_free;
  assign in_ready = !s1.valid || s2_free;
  assign accept   = in_valid && in_ready;

  // Stream positions
  logic [COL_W-1:0] in_col;
  logic [ROW_W:0]   in_row;
  logic [COL_W-1:0] out_c;
  logic [ROW_W-1:0] out_r;

  logic             in_done;
  logic             is_pix;
  logic             go;
  logic             emit;
  logic             last;
  logic [COL_W-1:0] adv_col;

  // Decide what the beat does and which column it touches
  always_comb begin
    in_done = (in_row == h_eff);
    is_pix  = !in_data.action && !in_done;
    go      = is_pix || in_done;
    emit    = in_done || (is_pix && ((in_row >= (ROW_W+1)'(2)) ||
              ((in_row == (ROW_W+1)'(1)) && (in_col != '0))));
    last    = (out_r == h_m1) && (out_c == w_m1);
    if (is_pix) begin
      adv_col = in_col;
    end else if (out_c == w_m1) begin
      adv_col = '0;
    end else begin
      adv_col = out_c + COL_W'(1);
    end
  end

  // Advance positions; drop both at end of frame or on a register write
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      in_col <= '0;
      in_row <= '0;
      out_c  <= '0;
      out_r  <= '0;
    end else if (accept && go) begin
      if (is_pix) begin
        if (in_col == w_m1) begin
          in_col <= '0;
          in_row <= in_row + (ROW_W+1)'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end
      if (emit) begin
        if (last) begin
          in_col <= '0;
          in_row <= '0;
          out_c  <= '0;
          out_r  <= '0;
        end else if (out_c == w_m1) begin
          out_c <= '0;
          out_r <= out_r + ROW_W'(1);
        end else begin
          out_c <= out_c + COL_W'(1);
        end
      end
    end
  end

  // Line stores
  bb3_pkg::pix_t two_rdata;
  bb3_pkg::pix_t one_rdata;
  bb3_pkg::pix_t two_eff;
  bb3_pkg::pix_t one_eff;

  assign two_eff = s1.fwd ? s1.fwd_two : two_rdata;
  assign one_eff = s1.fwd ? s1.fwd_one : one_rdata;

  bb3_ram #(.WIDTH(bb3_pkg::PIX_W), .DEPTH(bb3_pkg::MAX_WIDTH)) u_row_two (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1.col),
    .wdata (one_eff),
    .re    (accept),
    .raddr (adv_col),
    .rdata (two_rdata)
  );

  bb3_ram #(.WIDTH(bb3_pkg::PIX_W), .DEPTH(bb3_pkg::MAX_WIDTH)) u_row_one (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1.col),
    .wdata (s1.pix),
    .re    (accept),
    .raddr (adv_col),
    .rdata (one_rdata)
  );

  // Read stage: capture the beat, forward a same-column write of this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (accept) begin
      s1.valid <= go;
    end else if (s1_move) begin
      s1.valid <= 1'b0;
    end
    if (accept) begin
      s1.col     <= adv_col;
      s1.pix     <= is_pix ? {in_data.in_blue, in_data.in_green, in_data.in_red}
                           : '0;
      s1.emit    <= emit;
      s1.last    <= last;
      s1.left    <= (out_c != '0);
      s1.right   <= (out_c != w_m1);
      s1.top     <= (out_r != '0);
      s1.bottom  <= (out_r != h_m1);
      s1.fwd     <= s1_move && (s1.col == adv_col);
      s1.fwd_two <= one_eff;
      s1.fwd_one <= s1.pix;
    end
  end

  // Window of three columns by three rows
  bb3_pkg::pix_t win [9];
  bb3_pkg::pix_t win_next [9];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      win_next[k] = win[k+3];
    end
    win_next[6] = two_eff;
    win_next[7] = one_eff;
    win_next[8] = s1.pix;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else if (s1_move) begin
      win <= win_next;
    end
  end

  // Sum the in-bounds cells per channel and count them
  logic [2:0]       col_ok;
  logic [2:0]       row_ok;
  logic [SUM_W-1:0] sum [3];
  logic [1:0]       n_cols;
  logic [1:0]       n_rows;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    col_ok = {s1.right, 1'b1, s1.left};
    row_ok = {s1.bottom, 1'b1, s1.top};
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int k = 0; k < 9; k++) begin
        if (col_ok[k/3] && row_ok[k%3]) begin
          sum[ch] = sum[ch] + SUM_W'(win_next[k][8*ch +: 8]);
        end
      end
    end
    n_cols = 2'(1) + 2'(s1.left) + 2'(s1.right);
    n_rows = 2'(1) + 2'(s1.top) + 2'(s1.bottom);
    cnt    = CNT_W'(n_cols) * CNT_W'(n_rows);
  end

  // Sum stage
  logic [SUM_W-1:0] s2_sum [3];
  logic [CNT_W-1:0] s2_cnt;
  logic             s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move && s1.emit) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1.emit) begin
      s2_sum  <= sum;
      s2_cnt  <= cnt;
      s2_last <= s1.last;
    end
  end

  // Rounded mean: (2*sum + cnt) / (2*cnt) by reciprocal multiply
  logic [bb3_pkg::RECIP_W-1:0] m;
  logic [bb3_pkg::NUM_W-1:0]   num  [3];
  logic [bb3_pkg::PROD_W-1:0]  prod [3];
  logic [7:0]                  mean [3];

  always_comb begin
    m = bb3_pkg::recip(s2_cnt);
    for (int ch = 0; ch < 3; ch++) begin
      num[ch]  = {s2_sum[ch], 1'b0} + bb3_pkg::NUM_W'(s2_cnt);
      prod[ch] = bb3_pkg::PROD_W'(num[ch]) * bb3_pkg::PROD_W'(m);
      mean[ch] = prod[ch][bb3_pkg::QUOT_SHIFT +: 8];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_data.out_red    <= mean[0];
      out_data.out_green  <= mean[1];
      out_data.out_blue   <= mean[2];
      out_data.frame_last <= s2_last;
    end
  end

endmodule

// ----- sv/bb3_checker.sv -----
`timescale 1ns / 1ps
module bb3_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bb3_pkg::out_beat_t out_data
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result beat changed while stalled");

  // Reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat shown after reset");

  a_rst_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind box_blur_3x3_rgb_unit bb3_checker u_bb3_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
